/* rtl/lpr_pkg.sv */
// ----------------------------------------------------------------------------
// lpr_pkg
// Types and constants shared by the LRU page replacement unit.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int PAGE_BITS  = 16;
  localparam int COUNT_BITS = 16;
  localparam int SLOT_BITS  = 4;
  localparam int FC_BITS    = 5;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 2;

  // Frame count after reset
  localparam logic [FC_BITS-1:0] FC_RESET = FC_BITS'(16);

  // Register byte addresses
  localparam logic [APB_ADDR_W-1:0] REG_FRAME_COUNT = APB_ADDR_W'(0);

  typedef enum logic {
    OP_REFERENCE = 1'b0,
    OP_CLEAR     = 1'b1
  } lpr_op_t;

  typedef struct packed {
    lpr_op_t              opcode;
    logic [PAGE_BITS-1:0] page;
  } lpr_req_t;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_BITS-1:0]  slot;
    logic                  evicted_valid;
    logic [PAGE_BITS-1:0]  evicted_page;
    logic [COUNT_BITS-1:0] hit_total;
    logic [COUNT_BITS-1:0] miss_total;
  } lpr_rsp_t;

  // Outcome of one lookup
  typedef struct packed {
    logic hit;    // page already resident
    logic evict;  // no empty frame, least recent frame replaced
  } lpr_dec_t;

endpackage

/* rtl/lpr_lookup.sv */
// ----------------------------------------------------------------------------
// lpr_lookup
// Parallel tag compare, empty-frame search and LRU victim pick.
// ----------------------------------------------------------------------------
module lpr_lookup #(
  parameter int FRAMES_MAX = 16,
  parameter int IDX_W      = 4
) (
  input  logic [lpr_pkg::FC_BITS-1:0]   frame_count,
  input  logic [lpr_pkg::PAGE_BITS-1:0] page,
  input  logic                          clr,
  input  logic [lpr_pkg::PAGE_BITS-1:0] frame_page [FRAMES_MAX],
  input  logic [FRAMES_MAX-1:0]         frame_valid,
  input  logic [IDX_W-1:0]              frame_rank [FRAMES_MAX],
  output lpr_pkg::lpr_dec_t             dec,
  output logic [IDX_W-1:0]              slot,
  output logic [lpr_pkg::PAGE_BITS-1:0] evicted_page
);
  import lpr_pkg::*;

  localparam int CMP_W = (IDX_W > FC_BITS) ? IDX_W + 1 : FC_BITS + 1;

  logic [FRAMES_MAX-1:0] active;
  logic [FRAMES_MAX-1:0] eff_valid;
  logic [IDX_W-1:0]      eff_rank [FRAMES_MAX];
  logic [FRAMES_MAX-1:0] match;
  logic [FRAMES_MAX-1:0] empty;
  logic [FRAMES_MAX-1:0] oldest;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      empty_idx;
  logic [IDX_W-1:0]      victim_idx;

  // A count of zero still keeps frame 0; above FRAMES_MAX is bounded by j.
  always_comb begin
    for (int j = 0; j < FRAMES_MAX; j++) begin
      active[j]    = (j == 0) || (CMP_W'(j) < CMP_W'(frame_count));
      eff_valid[j] = frame_valid[j] & ~clr;
      eff_rank[j]  = clr ? '0 : frame_rank[j];
      match[j]     = active[j] & eff_valid[j] & (frame_page[j] == page);
      empty[j]     = active[j] & ~eff_valid[j];
    end
  end

  // Oldest frame: strictly older than lower frames, no younger than higher ones
  always_comb begin
    for (int j = 0; j < FRAMES_MAX; j++) begin
      oldest[j] = active[j];
      for (int k = 0; k < FRAMES_MAX; k++) begin
        if (active[k] && (k < j) && !(eff_rank[j] > eff_rank[k])) begin
          oldest[j] = 1'b0;
        end
        if (active[k] && (k > j) && (eff_rank[j] < eff_rank[k])) begin
          oldest[j] = 1'b0;
        end
      end
    end
  end

  // Lowest-index priority encoders
  always_comb begin
    hit_idx    = '0;
    empty_idx  = '0;
    victim_idx = '0;
    for (int j = FRAMES_MAX - 1; j >= 0; j--) begin
      if (match[j]) begin
        hit_idx = IDX_W'(j);
      end
      if (empty[j]) begin
        empty_idx = IDX_W'(j);
      end
      if (oldest[j]) begin
        victim_idx = IDX_W'(j);
      end
    end
  end

  always_comb begin
    dec.hit   = |match;
    dec.evict = ~(|match) & ~(|empty);
    if (|match) begin
      slot = hit_idx;
    end else if (|empty) begin
      slot = empty_idx;
    end else begin
      slot = victim_idx;
    end
    evicted_page = dec.evict ? frame_page[victim_idx] : '0;
  end

endmodule

/* rtl/lpr_frame_store.sv */
// ----------------------------------------------------------------------------
// lpr_frame_store
// Frame tags, valid bits and recency ranks with the LRU rank update.
// ----------------------------------------------------------------------------
module lpr_frame_store #(
  parameter int FRAMES_MAX = 16,
  parameter int IDX_W      = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          upd,
  input  logic                          clr,
  input  logic [IDX_W-1:0]              slot,
  input  logic [lpr_pkg::PAGE_BITS-1:0] page,
  output logic [lpr_pkg::PAGE_BITS-1:0] frame_page [FRAMES_MAX],
  output logic [FRAMES_MAX-1:0]         frame_valid,
  output logic [IDX_W-1:0]              frame_rank [FRAMES_MAX]
);
  import lpr_pkg::*;

  logic [FRAMES_MAX-1:0] eff_valid;
  logic [IDX_W-1:0]      eff_rank [FRAMES_MAX];
  logic [FRAMES_MAX-1:0] valid_next;
  logic [IDX_W-1:0]      rank_next [FRAMES_MAX];
  logic [IDX_W-1:0]      slot_rank;
  logic                  slot_was_valid;

  always_comb begin
    for (int j = 0; j < FRAMES_MAX; j++) begin
      eff_valid[j] = frame_valid[j] & ~clr;
      eff_rank[j]  = clr ? '0 : frame_rank[j];
    end
    slot_rank      = eff_rank[slot];
    slot_was_valid = eff_valid[slot];
    // Age frames younger than the touched one; a new frame ages all of them
    for (int j = 0; j < FRAMES_MAX; j++) begin
      valid_next[j] = eff_valid[j] | (IDX_W'(j) == slot);
      if (IDX_W'(j) == slot) begin
        rank_next[j] = '0;
      end else if (eff_valid[j] && (!slot_was_valid || (eff_rank[j] < slot_rank))) begin
        rank_next[j] = eff_rank[j] + IDX_W'(1);
      end else begin
        rank_next[j] = eff_rank[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      for (int j = 0; j < FRAMES_MAX; j++) begin
        frame_rank[j] <= '0;
      end
    end else if (upd) begin
      frame_valid <= valid_next;
      for (int j = 0; j < FRAMES_MAX; j++) begin
        frame_rank[j] <= rank_next[j];
      end
    end
  end

  // Tags need no reset; a hit rewrites the same page
  always_ff @(posedge clk) begin
    if (upd) begin
      frame_page[slot] <= page;
    end
  end

endmodule

/* rtl/lru_page_replacement.sv */
// An accepted request passes through the input register, then the result
// register, which raises its result strobe.
// Throughput: one request every cycle; busy never rises.
// Reset: synchronous; clears all frames, ranks and counts, frame count to 16.
// The receiver cannot stall; done is a single-cycle strobe.
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU page frame tracker with saturating hit/miss counts,
// configured over an APB-style port.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
  parameter int FRAMES_MAX = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  lpr_pkg::lpr_req_t              req,
  output logic                           done,
  output lpr_pkg::lpr_rsp_t              rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lpr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lpr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lpr_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import lpr_pkg::*;

  localparam int IDX_W = (FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1;

  // Configuration
  logic [FC_BITS-1:0] frame_count;

  // Input register
  lpr_req_t req_q;
  logic     req_valid;

  // Frame state
  logic [PAGE_BITS-1:0]  frame_page [FRAMES_MAX];
  logic [FRAMES_MAX-1:0] frame_valid;
  logic [IDX_W-1:0]      frame_rank [FRAMES_MAX];

  // Lookup outcome
  lpr_dec_t             dec;
  logic [IDX_W-1:0]     slot;
  logic [PAGE_BITS-1:0] evicted_page;
  logic                 clr;

  // Running counts
  logic [COUNT_BITS-1:0] hits_seen;
  logic [COUNT_BITS-1:0] faults_seen;
  logic [COUNT_BITS-1:0] hits_base;
  logic [COUNT_BITS-1:0] faults_base;
  logic [COUNT_BITS-1:0] hits_seen_next;
  logic [COUNT_BITS-1:0] faults_seen_next;

  // --------------------------------------------------------------------------
  // Handshake: every request is taken, the state update for one request
  // completes before the next request reaches the lookup stage.
  // --------------------------------------------------------------------------
  assign busy   = 1'b0;
  assign pready = 1'b1;

  // --------------------------------------------------------------------------
  // Configuration port: write on the access phase, read back frame_count
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FC_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == REG_FRAME_COUNT)) begin
      frame_count <= pwdata[FC_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_FRAME_COUNT) begin
      prdata = APB_DATA_W'(frame_count);
    end
  end

  // --------------------------------------------------------------------------
  // Input register: hold the request for the lookup cycle
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
  end

  // A clear request acts on the state as seen by its own lookup
  assign clr = req_valid && (req_q.opcode == OP_CLEAR);

  // --------------------------------------------------------------------------
  // Lookup: tag match, first empty frame, least recent frame
  // --------------------------------------------------------------------------
  lpr_lookup #(
    .FRAMES_MAX (FRAMES_MAX),
    .IDX_W      (IDX_W)
  ) u_lookup (
    .frame_count  (frame_count),
    .page         (req_q.page),
    .clr          (clr),
    .frame_page   (frame_page),
    .frame_valid  (frame_valid),
    .frame_rank   (frame_rank),
    .dec          (dec),
    .slot         (slot),
    .evicted_page (evicted_page)
  );

  // --------------------------------------------------------------------------
  // Frame state: write the tag, set valid, advance the recency order
  // --------------------------------------------------------------------------
  lpr_frame_store #(
    .FRAMES_MAX (FRAMES_MAX),
    .IDX_W      (IDX_W)
  ) u_frame_store (
    .clk         (clk),
    .rst         (rst),
    .upd         (req_valid),
    .clr         (clr),
    .slot        (slot),
    .page        (req_q.page),
    .frame_page  (frame_page),
    .frame_valid (frame_valid),
    .frame_rank  (frame_rank)
  );

  // --------------------------------------------------------------------------
  // Saturating counts: drop to zero on clear, stop at all ones
  // --------------------------------------------------------------------------
  always_comb begin
    hits_base        = clr ? '0 : hits_seen;
    faults_base      = clr ? '0 : faults_seen;
    hits_seen_next   = hits_base;
    faults_seen_next = faults_base;
    if (dec.hit) begin
      if (hits_base != '1) begin
        hits_seen_next = hits_base + COUNT_BITS'(1);
      end
    end else begin
      if (faults_base != '1) begin
        faults_seen_next = faults_base + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hits_seen   <= '0;
      faults_seen <= '0;
    end else if (req_valid) begin
      hits_seen   <= hits_seen_next;
      faults_seen <= faults_seen_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: one strobe per request
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      rsp.hit           <= dec.hit;
      rsp.slot          <= SLOT_BITS'(slot);
      rsp.evicted_valid <= dec.evict;
      rsp.evicted_page  <= evicted_page;
      rsp.hit_total     <= hits_seen_next;
      rsp.miss_total    <= faults_seen_next;
    end
  end

`ifndef SYNTHESIS
  // Every accepted request is answered by a result strobe
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("request accepted but no result strobe");

  // An eviction only happens on a miss
  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.hit && rsp.evicted_valid))
    else $error("eviction reported on a hit");

  // No evicted page is reported without an eviction
  a_evict_page_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.evicted_valid) |-> (rsp.evicted_page == '0))
    else $error("evicted page non-zero without eviction");

  // A miss that is not a clear leaves the hit count untouched
  a_miss_keeps_hits: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !clr && !dec.hit) |=> (hits_seen == $past(hits_seen)))
    else $error("hit count moved on a miss");
`endif

endmodule

/* tb/tb_lru_page_replacement.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_page_replacement
// Self-checking bench for the LRU page replacement unit. Page references are
// pushed through the command port, and the frame count is set over APB
// between phases. A behavioural copy of the frame set predicts every
// response, and the responses are compared field by field in order.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement;
  import lpr_pkg::*;

  localparam int FRAME_SLOTS = 16;
  localparam int PHASES      = 8;
  localparam int PHASE_LEN   = 230;

  // Behavioural frame set: predicts the response to every accepted request.
  class page_tracker;
    logic [PAGE_BITS-1:0]  held_page [FRAME_SLOTS];
    bit                    in_use    [FRAME_SLOTS];
    logic [SLOT_BITS-1:0]  age_rank  [FRAME_SLOTS];
    logic [COUNT_BITS-1:0] hit_tally;
    logic [COUNT_BITS-1:0] miss_tally;
    logic [FC_BITS-1:0]    slots_cfg;
    lpr_rsp_t              due_outcomes [$];
    int                    errors;

    function new();
      slots_cfg = FC_RESET;
      errors    = 0;
      foreach (held_page[j]) held_page[j] = '0;
      wipe();
    endfunction

    function void wipe();
      foreach (in_use[j]) begin
        in_use[j]   = 1'b0;
        age_rank[j] = '0;
      end
      hit_tally  = '0;
      miss_tally = '0;
    endfunction

    function void set_frame_count(logic [FC_BITS-1:0] v);
      slots_cfg = v;
    endfunction

    function int pending();
      return due_outcomes.size();
    endfunction

    // Make frame f the most recent; every valid frame younger than it ages.
    function void promote(int f);
      logic [SLOT_BITS-1:0] r;
      r = age_rank[f];
      for (int j = 0; j < FRAME_SLOTS; j++)
        if (in_use[j] && (!in_use[f] || (j != f && age_rank[j] < r)))
          age_rank[j] = age_rank[j] + 1'b1;
      age_rank[f] = '0;
    endfunction

    function void note_request(lpr_req_t r);
      lpr_rsp_t             o;
      int                   active;
      int                   slot;
      bit                   found;
      logic [SLOT_BITS-1:0] oldest;
      o     = '0;
      slot  = 0;
      found = 1'b0;
      if (r.opcode == OP_CLEAR) wipe();
      active = (slots_cfg == 0) ? 1 : (slots_cfg > FRAME_SLOTS) ? FRAME_SLOTS : int'(slots_cfg);

      // Lowest-numbered matching frame in use wins, even with duplicates
      for (int j = 0; j < active; j++)
        if (!found && in_use[j] && held_page[j] == r.page) begin
          slot  = j;
          found = 1'b1;
        end

      if (found) begin
        o.hit = 1'b1;
        promote(slot);
        if (hit_tally != '1) hit_tally++;
      end else begin
        for (int j = 0; j < active; j++)
          if (!found && !in_use[j]) begin
            slot  = j;
            found = 1'b1;
          end
        if (!found) begin
          // Replace the oldest frame in use; ties go to the lower index
          oldest = '0;
          for (int j = 0; j < active; j++)
            if (j == 0 || age_rank[j] > oldest) begin
              oldest = age_rank[j];
              slot   = j;
            end
          o.evicted_valid = 1'b1;
          o.evicted_page  = held_page[slot];
        end
        promote(slot);
        held_page[slot] = r.page;
        in_use[slot]    = 1'b1;
        if (miss_tally != '1) miss_tally++;
      end

      o.slot       = SLOT_BITS'(slot);
      o.hit_total  = hit_tally;
      o.miss_total = miss_tally;
      due_outcomes.push_back(o);
    endfunction

    function void match_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_response(lpr_rsp_t got);
      lpr_rsp_t want;
      if (due_outcomes.size() == 0) begin
        $error("response strobe with no request outstanding");
        errors++;
        return;
      end
      want = due_outcomes.pop_front();
      match_field("hit", 32'(want.hit), 32'(got.hit));
      match_field("slot", 32'(want.slot), 32'(got.slot));
      match_field("evicted_valid", 32'(want.evicted_valid), 32'(got.evicted_valid));
      match_field("evicted_page", 32'(want.evicted_page), 32'(got.evicted_page));
      match_field("hit_total", 32'(want.hit_total), 32'(got.hit_total));
      match_field("miss_total", 32'(want.miss_total), 32'(got.miss_total));
    endfunction
  endclass

  logic                  clk     = 1'b0;
  logic                  rst     = 1'b1;
  logic                  start   = 1'b0;
  lpr_req_t              req     = '0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic                  busy;
  logic                  done;
  lpr_rsp_t              rsp;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  page_tracker tracker;

  lru_page_replacement dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sample the response strobe with the values held before the edge.
  always @(posedge clk) begin
    if (!rst && done) tracker.check_response(rsp);
  end

  // Hard stop in case a request is never accepted or a response never comes.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Present one request and hold it until the block takes it. When allowed,
  // drop start for a random pause first so that gaps land in every phase that allows them.
  task automatic issue_request(lpr_req_t r, bit may_pause);
    if (may_pause && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    tracker.note_request(r);
  endtask

  task automatic directed(lpr_op_t op, logic [PAGE_BITS-1:0] p);
    lpr_req_t r;
    r.opcode = op;
    r.page   = p;
    issue_request(r, 1'b0);
  endtask

  // Drop start and wait until every outstanding response has arrived, then
  // allow the two-stage pipeline to empty out completely.
  task automatic settle();
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write of the frame count: setup cycle, then access until pready.
  task automatic write_frame_count(logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_FRAME_COUNT;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_frame_count(data[FC_BITS-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random phase: mostly references drawn from a small working set around a
  // random base so hits, fills and evictions all occur, with some pages from
  // the whole range and the odd clear. Hold off once mid-phase until drained.
  task automatic run_phase(bit calm);
    lpr_req_t             r;
    logic [PAGE_BITS-1:0] base;
    int                   ws;
    int                   pick;
    base = PAGE_BITS'($urandom);
    ws   = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 24);
    for (int i = 0; i < PHASE_LEN; i++) begin
      if (i == PHASE_LEN / 2) settle();
      pick     = $urandom_range(0, 99);
      r.opcode = (pick < 3) ? OP_CLEAR : OP_REFERENCE;
      if (pick < 88)
        r.page = base + PAGE_BITS'($urandom_range(0, ws - 1));
      else
        r.page = PAGE_BITS'($urandom);
      issue_request(r, !calm);
    end
  endtask

  initial begin
    logic [APB_DATA_W-1:0] cfg;
    tracker = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Fill from empty at the reset frame count, hit both page extremes
    directed(OP_CLEAR, 16'h0000);
    directed(OP_REFERENCE, 16'hFFFF);
    directed(OP_REFERENCE, 16'h0000);
    directed(OP_REFERENCE, 16'hFFFF);
    directed(OP_REFERENCE, 16'h8000);
    directed(OP_REFERENCE, 16'h0001);

    // Shrink to two frames: evict the least recent, outer frames go stale
    settle();
    write_frame_count(32'd2);
    directed(OP_REFERENCE, 16'h1234);
    directed(OP_REFERENCE, 16'h0000);
    directed(OP_REFERENCE, 16'h1234);

    // A count of zero behaves as one frame; park a copy of a stale page
    settle();
    write_frame_count(32'd0);
    directed(OP_REFERENCE, 16'h00AA);
    directed(OP_REFERENCE, 16'h00AA);
    directed(OP_REFERENCE, 16'h8000);

    // Oversized count saturates to all frames; duplicate resolves to frame 0
    settle();
    write_frame_count(32'hFFFF_FFFF);
    directed(OP_REFERENCE, 16'h8000);
    directed(OP_REFERENCE, 16'h1234);
    directed(OP_REFERENCE, 16'h0001);
    directed(OP_CLEAR, 16'hFFFF);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0:       cfg = 32'd1;
        1:       cfg = 32'd16;
        2:       cfg = 32'd0;
        3:       cfg = 32'd31;
        default: cfg = {$urandom} & 32'hFFFF_FFE0 | 32'($urandom_range(0, 31));
      endcase
      write_frame_count(cfg);
      // Phase two runs back to back with no random pauses
      run_phase(ph == 2);
    end

    settle();
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
